// ===== sv/dcwm_pkg.sv =====
// Shared types, constants and helpers for the dark channel window minimum block.
// No dependencies; every other file except dcwm_ram imports this package.
package dcwm_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int MAX_PATCH = 15;
    localparam int NUM_LINES = MAX_PATCH - 1;
    localparam int TREE_N    = 2 ** $clog2(MAX_PATCH);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int DIM_W   = 11;
    localparam int ROW_W   = 12;
    localparam int PATCH_W = 4;
    localparam int CHAN_W  = 8;
    localparam int RECIP_W = 18;
    localparam int PROD_W  = CHAN_W + RECIP_W;
    localparam int VAL_W   = 12;
    localparam int LAG_W   = 13;
    localparam int IDX_W   = 3;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_PATCH_WIDTH  = 3'd2,
        REG_PATCH_HEIGHT = 3'd3,
        REG_RECIP_BLUE   = 3'd4,
        REG_RECIP_GREEN  = 3'd5,
        REG_RECIP_RED    = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue_value;
        logic [CHAN_W-1:0] green_value;
        logic [CHAN_W-1:0] red_value;
        logic              drain;
    } pix_t;

    typedef struct packed {
        logic [VAL_W-1:0] dark_value;
        logic             last_of_frame;
    } dark_t;

    typedef struct packed {
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [PATCH_W-1:0] patch_width;
        logic [PATCH_W-1:0] patch_height;
    } geom_t;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [ROW_W-1:0]   rbot;
        logic               isdata;
        logic               emit;
        logic               last;
        logic [PATCH_W-1:0] pw;
        logic [PATCH_W-1:0] ph;
        logic               frame;
    } tick_t;

    typedef struct packed {
        logic             valid;
        logic             frame;
        logic [ROW_W-1:0] row;
        logic [VAL_W-1:0] value;
    } win_t;

    localparam win_t WIN_EMPTY = '{valid: 1'b0, frame: 1'b0, row: '0, value: VAL_MAX};

    function automatic logic [VAL_W-1:0] min_val(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [VAL_W-1:0] min_tree(input logic [TREE_N-1:0][VAL_W-1:0] v);
        logic [TREE_N-1:0][VAL_W-1:0] t;
        t = v;
        for (int s = TREE_N >> 1; s >= 1; s = s >> 1) begin
            for (int i = 0; i < s; i++) begin
                t[i] = min_val(t[2*i], t[2*i+1]);
            end
        end
        return t[0];
    endfunction

    function automatic logic [VAL_W-1:0] normalize(input logic [PROD_W-1:0] prod);
        logic [PROD_W:0]         sum;
        logic [PROD_W-8:0]       sh;
        sum = {1'b0, prod} + (PROD_W+1)'(128);
        sh  = sum[PROD_W:8];
        return (|sh[PROD_W-8:VAL_W]) ? VAL_MAX : sh[VAL_W-1:0];
    endfunction

endpackage

// ===== sv/dcwm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dcwm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/dcwm_line_cell.sv =====
// One line-delay cell: a row of channel minima in RAM, with same-column forwarding.
// Depends on dcwm_pkg and dcwm_ram.
module dcwm_line_cell
    import dcwm_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  logic [VAL_W-1:0] wr_data,
    input  logic             byp,
    output logic [VAL_W-1:0] line_value
);

    logic [VAL_W-1:0] rd_data;
    logic [VAL_W-1:0] lastw_reg;

    dcwm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // hold the last write for a read that collided with it
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lastw_reg <= wr_data;
        end
    end

    assign line_value = byp ? lastw_reg : rd_data;

endmodule

// ===== sv/dcwm_win_cell.sv =====
// One horizontal window cell: holds a column minimum with its row tag and masks it.
// Depends on dcwm_pkg.
module dcwm_win_cell
    import dcwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  win_t             din,
    input  logic             en,
    input  logic             frame,
    input  logic [ROW_W-1:0] rbot,
    output win_t             dout,
    output logic [VAL_W-1:0] masked
);

    win_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '{valid: 1'b0, frame: 1'b0, row: '0, value: VAL_MAX};
        end
        else if (shift)
        begin
            entry_reg <= din;
        end
    end

    assign dout   = entry_reg;
    assign masked = (en && entry_reg.valid && (entry_reg.frame == frame)
                     && (entry_reg.row == rbot)) ? entry_reg.value : VAL_MAX;

endmodule

// ===== sv/dcwm_ctrl.sv =====
// Frame sequencer: latches geometry, tracks input and output raster positions.
// Depends on dcwm_pkg.
module dcwm_ctrl
    import dcwm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  logic  drain,
    input  geom_t geom,
    output logic  tick,
    output tick_t info
);

    logic               active_reg, active_next;
    logic               frame_reg, frame_next;
    logic [DIM_W-1:0]   w_reg, w_next;
    logic [DIM_W-1:0]   h_reg, h_next;
    logic [PATCH_W-1:0] pw_reg, pw_next;
    logic [PATCH_W-1:0] ph_reg, ph_next;
    logic [PATCH_W-1:0] bh_reg, bh_next;
    logic [COL_W-1:0]   tk_col_reg, tk_col_next;
    logic [ROW_W-1:0]   tk_row_reg, tk_row_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [DIM_W-1:0]   out_row_reg, out_row_next;
    logic [LAG_W-1:0]   lead_reg, lead_next;

    logic                       start;
    logic [DIM_W-1:0]           w_cl, h_cl;
    logic [PATCH_W-1:0]         pw_cl, ph_cl, bh_cl, bw_cl;
    logic [PATCH_W+DIM_W-1:0]   lag_mul;
    logic [LAG_W-1:0]           lag;
    logic [DIM_W-1:0]           w_e, h_e;
    logic [PATCH_W-1:0]         pw_e, ph_e, bh_e;
    logic                       frame_e;
    logic [COL_W-1:0]           tk_col_e, out_col_e;
    logic [ROW_W-1:0]           tk_row_e;
    logic [DIM_W-1:0]           out_row_e;
    logic [LAG_W-1:0]           lead_e;
    logic                       emit, last, tk_wrap, out_wrap;

    always_comb
    begin
        w_cl = (geom.image_width == '0) ? DIM_W'(1)
             : (geom.image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : geom.image_width;
        h_cl  = (geom.image_height == '0) ? DIM_W'(1) : geom.image_height;
        pw_cl = (geom.patch_width == '0) ? PATCH_W'(1)
              : (geom.patch_width > PATCH_W'(MAX_PATCH)) ? PATCH_W'(MAX_PATCH)
              : geom.patch_width;
        ph_cl = (geom.patch_height == '0) ? PATCH_W'(1)
              : (geom.patch_height > PATCH_W'(MAX_PATCH)) ? PATCH_W'(MAX_PATCH)
              : geom.patch_height;
        bh_cl   = ph_cl - PATCH_W'(1) - (ph_cl >> 1);
        bw_cl   = pw_cl - PATCH_W'(1) - (pw_cl >> 1);
        lag_mul = bh_cl * w_cl;
        lag     = LAG_W'(lag_mul) + LAG_W'(bw_cl);

        start     = step && !drain && !active_reg;
        w_e       = start ? w_cl : w_reg;
        h_e       = start ? h_cl : h_reg;
        pw_e      = start ? pw_cl : pw_reg;
        ph_e      = start ? ph_cl : ph_reg;
        bh_e      = start ? bh_cl : bh_reg;
        frame_e   = start ? ~frame_reg : frame_reg;
        tk_col_e  = start ? '0 : tk_col_reg;
        tk_row_e  = start ? '0 : tk_row_reg;
        out_col_e = start ? '0 : out_col_reg;
        out_row_e = start ? '0 : out_row_reg;
        lead_e    = start ? lag : lead_reg;

        tick = step && (!drain || (active_reg && (tk_row_reg >= ROW_W'(h_reg))));

        emit     = (lead_e == '0);
        tk_wrap  = ({1'b0, tk_col_e} == (w_e - DIM_W'(1)));
        out_wrap = ({1'b0, out_col_e} == (w_e - DIM_W'(1)));
        last     = emit && out_wrap && (out_row_e == (h_e - DIM_W'(1)));

        info.col    = tk_col_e;
        info.row    = tk_row_e;
        info.rbot   = ROW_W'(out_row_e) + ROW_W'(bh_e);
        info.isdata = !drain && (tk_row_e < ROW_W'(h_e));
        info.emit   = emit;
        info.last   = last;
        info.pw     = pw_e;
        info.ph     = ph_e;
        info.frame  = frame_e;

        active_next  = active_reg;
        frame_next   = frame_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        pw_next      = pw_reg;
        ph_next      = ph_reg;
        bh_next      = bh_reg;
        tk_col_next  = tk_col_reg;
        tk_row_next  = tk_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lead_next    = lead_reg;
        if (tick)
        begin
            active_next  = !last;
            frame_next   = frame_e;
            w_next       = w_e;
            h_next       = h_e;
            pw_next      = pw_e;
            ph_next      = ph_e;
            bh_next      = bh_e;
            tk_col_next  = tk_wrap ? '0 : tk_col_e + COL_W'(1);
            tk_row_next  = tk_wrap ? tk_row_e + ROW_W'(1) : tk_row_e;
            out_col_next = out_col_e;
            out_row_next = out_row_e;
            lead_next    = emit ? '0 : lead_e - LAG_W'(1);
            if (emit)
            begin
                out_col_next = out_wrap ? '0 : out_col_e + COL_W'(1);
                out_row_next = out_wrap ? out_row_e + DIM_W'(1) : out_row_e;
            end
            if (last)
            begin
                tk_col_next  = '0;
                tk_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            frame_reg   <= 1'b0;
            w_reg       <= DIM_W'(1);
            h_reg       <= DIM_W'(1);
            pw_reg      <= PATCH_W'(1);
            ph_reg      <= PATCH_W'(1);
            bh_reg      <= '0;
            tk_col_reg  <= '0;
            tk_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lead_reg    <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            frame_reg   <= frame_next;
            w_reg       <= w_next;
            h_reg       <= h_next;
            pw_reg      <= pw_next;
            ph_reg      <= ph_next;
            bh_reg      <= bh_next;
            tk_col_reg  <= tk_col_next;
            tk_row_reg  <= tk_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lead_reg    <= lead_next;
        end
    end

endmodule

// ===== sv/dark_channel_window_min_top.sv =====
// Top level of the dark channel window minimum block.
// Depends on dcwm_pkg, dcwm_ctrl, dcwm_line_cell and dcwm_win_cell.
//
// Usage:
//   pix channel: one transaction per pixel in raster order (blue, green, red),
//   or a drain transaction that only advances the flush after the last pixel.
//   dark channel: one transaction per output pixel, raster order, with
//   last_of_frame on the final one. Results lag the input by
//   bh*width + bw ticks (bh, bw = lower/right half of the patch), so drain
//   transactions flush the tail of a frame.
//   cfg channel: index/data writes, always ready; write only while idle.
//   Geometry is latched on the first pixel of a frame.
// Timing:
//   One transaction per clock unless a stalled result waits. A released result
//   passes stages b, c and d into the output register. The rate is set by one
//   read and one write per cycle on each line RAM of the vertical chain.
// Reset: control and window cells clear; line RAMs need no clearing.
// Stall: dark_stall with a waiting result freezes the whole pipeline and
//   raises pix_stall in the same cycle.
module dark_channel_window_min_top
    import dcwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_stall,
    input  pix_t               pix,
    output logic               dark_valid,
    input  logic               dark_stall,
    output dark_t              dark,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [RECIP_W-1:0] cfg_data
);

    geom_t              geom_reg;
    logic [RECIP_W-1:0] recip_b_reg, recip_g_reg, recip_r_reg;

    logic  adv, step, tick;
    tick_t a_info;

    logic              b_valid_reg;
    tick_t             b_info_reg;
    logic              b_byp_reg;
    logic [PROD_W-1:0] b_prod_b_reg, b_prod_g_reg, b_prod_r_reg;

    logic              c_valid_reg;
    tick_t             c_info_reg;
    logic [VAL_W-1:0]  c_v_reg;

    logic              d_valid_reg;
    tick_t             d_info_reg;

    logic  out_valid_reg;
    dark_t out_reg;

    logic [VAL_W-1:0]             pix_min;
    logic [NUM_LINES-1:0][VAL_W-1:0] line_value;
    logic [TREE_N-1:0][VAL_W-1:0] vmask;
    logic [TREE_N-1:0][VAL_W-1:0] hmask;
    logic [VAL_W-1:0]             vmin, hmin;
    win_t [MAX_PATCH-1:0]         win_q;
    win_t                         win_in;
    logic                         win_flush;
    logic                         byp_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.image_width  <= DIM_W'(640);
            geom_reg.image_height <= DIM_W'(480);
            geom_reg.patch_width  <= PATCH_W'(15);
            geom_reg.patch_height <= PATCH_W'(15);
            recip_b_reg           <= RECIP_W'(1028);
            recip_g_reg           <= RECIP_W'(1028);
            recip_r_reg           <= RECIP_W'(1028);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:  geom_reg.image_width  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: geom_reg.image_height <= cfg_data[DIM_W-1:0];
                REG_PATCH_WIDTH:  geom_reg.patch_width  <= cfg_data[PATCH_W-1:0];
                REG_PATCH_HEIGHT: geom_reg.patch_height <= cfg_data[PATCH_W-1:0];
                REG_RECIP_BLUE:   recip_b_reg           <= cfg_data;
                REG_RECIP_GREEN:  recip_g_reg           <= cfg_data;
                REG_RECIP_RED:    recip_r_reg           <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign adv       = !(out_valid_reg && dark_stall);
    assign pix_stall = !adv;
    assign step      = pix_valid && adv;

    dcwm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .drain (pix.drain),
        .geom  (geom_reg),
        .tick  (tick),
        .info  (a_info)
    );

    assign byp_next = b_valid_reg && (b_info_reg.col == a_info.col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg   <= tick;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= d_valid_reg && d_info_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_info_reg   <= a_info;
            b_byp_reg    <= byp_next;
            b_prod_b_reg <= pix.blue_value * recip_b_reg;
            b_prod_g_reg <= pix.green_value * recip_g_reg;
            b_prod_r_reg <= pix.red_value * recip_r_reg;
            c_info_reg   <= b_info_reg;
            c_v_reg      <= vmin;
            d_info_reg   <= c_info_reg;
            out_reg      <= '{dark_value: hmin, last_of_frame: d_info_reg.last};
        end
    end

    assign pix_min = b_info_reg.isdata
                   ? min_val(min_val(normalize(b_prod_b_reg), normalize(b_prod_g_reg)),
                             normalize(b_prod_r_reg))
                   : VAL_MAX;

    for (genvar gi = 0; gi < NUM_LINES; gi++)
    begin : g_line
        dcwm_line_cell u_line (
            .clk        (clk),
            .rd_en      (tick && adv),
            .rd_addr    (a_info.col),
            .wr_en      (adv && b_valid_reg),
            .wr_addr    (b_info_reg.col),
            .wr_data    ((gi == 0) ? pix_min : line_value[(gi == 0) ? 0 : gi-1]),
            .byp        (b_byp_reg),
            .line_value (line_value[gi])
        );
    end

    always_comb
    begin
        vmask = {TREE_N{VAL_MAX}};
        vmask[0] = pix_min;
        for (int k = 1; k < MAX_PATCH; k++)
        begin
            vmask[k] = ((PATCH_W'(k) < b_info_reg.ph) && (ROW_W'(k) <= b_info_reg.row))
                     ? line_value[k-1] : VAL_MAX;
        end
        vmin = min_tree(vmask);
    end

    assign win_in = '{valid: 1'b1, frame: c_info_reg.frame, row: c_info_reg.row,
                      value: c_v_reg};

    // drop entries of earlier frames when the first column of a new frame enters
    assign win_flush = (win_in.frame != win_q[0].frame);

    for (genvar gk = 0; gk < MAX_PATCH; gk++)
    begin : g_win
        dcwm_win_cell u_win (
            .clk    (clk),
            .rst_n  (rst_n),
            .shift  (adv && c_valid_reg),
            .din    ((gk == 0) ? win_in
                     : (win_flush ? WIN_EMPTY : win_q[(gk == 0) ? 0 : gk-1])),
            .en     (PATCH_W'(gk) < d_info_reg.pw),
            .frame  (d_info_reg.frame),
            .rbot   (d_info_reg.rbot),
            .dout   (win_q[gk]),
            .masked (hmask[gk])
        );
    end

    for (genvar gp = MAX_PATCH; gp < TREE_N; gp++)
    begin : g_pad
        assign hmask[gp] = VAL_MAX;
    end

    assign hmin = min_tree(hmask);

    assign dark_valid = out_valid_reg;
    assign dark       = out_reg;

endmodule

// ===== sv/dcwm_checker.sv =====
// Port-level checker for the dark channel window minimum block, bound to the top level.
// Depends on dcwm_pkg and dark_channel_window_min_top.
module dcwm_checker
    import dcwm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               pix_valid,
    input logic               pix_stall,
    input pix_t               pix,
    input logic               dark_valid,
    input logic               dark_stall,
    input dark_t              dark,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [IDX_W-1:0]   cfg_index,
    input logic [RECIP_W-1:0] cfg_data
);

    // hold a stalled result
    a_dark_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dark_valid && dark_stall |=> dark_valid && $stable(dark))
        else $error("stalled result changed or dropped");

    // drop valid only after a transaction
    a_dark_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(dark_valid) |-> $past(!dark_stall))
        else $error("result withdrawn without transaction");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> dark_valid && dark_stall)
        else $error("input stalled while output free");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind dark_channel_window_min_top dcwm_checker u_dcwm_checker (.*);
